// ----- hw/rtl/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// shared widths, constants and operation codes of the ring-buffer deque
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH  = 16;
	localparam int ITEM_W = 32;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = 5;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [ITEM_W-1:0] EMPTY_ITEM = '1;

	typedef enum logic [1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_PUSH_REAR  = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_REAR   = 2'd3
	} mode_t;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

endpackage

// ----- hw/rtl/circular_double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// bounded deque in a ring buffer with push and pop at both ends
// ----------------------------------------------------------------------------
// usage
//   command beat: start with mode and value, taken when start is high and busy
//   is low. busy stays low, so a command may follow in every cycle.
//   result beat: one per command, shown for a single cycle with result_valid
//   high, in the cycle after the command edge (throughput 1 per cycle).
//   the rate is set by the item memory: one write port and two registered read
//   ports, all used in the command cycle. a read of the entry written in the
//   same cycle is forwarded from the write data.
//   config: apb register 0 holds the capacity (1..16, clamped); writing it
//   empties the deque. write only while no result is pending.
//   reset: capacity 16, deque empty, no result pending. the item memory is not
//   cleared; empty entries are never shown since an empty deque reports -1.
//   the receiver cannot stall: a result beat not taken in its cycle is lost.
// ----------------------------------------------------------------------------
module circular_double_ended_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	// apb config port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdq_pkg::ADDR_W-1:0]    paddr,
	input  logic [cdq_pkg::DATA_W-1:0]    pwdata,
	output logic [cdq_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// command beat
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    mode,
	input  logic signed [cdq_pkg::ITEM_W-1:0] value,
	// result beat
	output logic                          result_valid,
	output logic                          accepted,
	output logic signed [cdq_pkg::ITEM_W-1:0] front_item,
	output logic signed [cdq_pkg::ITEM_W-1:0] rear_item,
	output logic                          is_empty,
	output logic                          is_full
);
	import cdq_pkg::*;

	// ring index helpers, wrap at the configured capacity
	function automatic logic [PTR_W-1:0] step_up(logic [PTR_W-1:0] p, logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] nxt;
		nxt = CNT_W'(p) + CNT_W'(1);
		return (nxt >= cap) ? '0 : nxt[PTR_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] step_down(logic [PTR_W-1:0] p, logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] last;
		last = cap - CNT_W'(1);
		return (p == '0) ? last[PTR_W-1:0] : p - PTR_W'(1);
	endfunction

	// item memory
	logic [ITEM_W-1:0] mem_q [DEPTH];

	// deque control state
	logic [CNT_W-1:0] cap_q;
	logic [PTR_W-1:0] front_q;
	logic [PTR_W-1:0] rear_q;
	logic [CNT_W-1:0] count_q;

	// result stage
	logic              valid_s1;
	logic              done_s1;
	logic              empty_s1;
	logic              full_s1;
	logic [ITEM_W-1:0] rd_front_s1;
	logic [ITEM_W-1:0] rd_rear_s1;

	logic             cmd_take;
	logic             cfg_wr;
	logic [CAP_W-1:0] cfg_raw;
	logic [CNT_W-1:0] cfg_cap;
	logic             full_now;
	logic             empty_now;
	logic [PTR_W-1:0] front_nxt;
	logic [PTR_W-1:0] rear_nxt;
	logic [CNT_W-1:0] count_nxt;
	logic             done_nxt;
	logic             mem_we;
	logic [PTR_W-1:0] mem_waddr;
	logic [PTR_W-1:0] rd_front_addr;
	logic [PTR_W-1:0] rd_rear_addr;

	// every command finishes its memory work in the cycle it is taken
	assign busy     = 1'b0;
	assign cmd_take = start && !busy;

	// apb access, no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
	assign cfg_raw = pwdata[CAP_W-1:0];

	always_comb begin
		if (cfg_raw == '0) begin
			cfg_cap = CNT_W'(1);
		end else if (int'(cfg_raw) > DEPTH) begin
			cfg_cap = CNT_W'(DEPTH);
		end else begin
			cfg_cap = CNT_W'(cfg_raw);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CAPACITY) begin
			prdata = DATA_W'(cap_q);
		end
	end

	assign full_now  = (count_q >= cap_q);
	assign empty_now = (count_q == '0);

	// next pointers and the single memory write of this command
	always_comb begin
		front_nxt = front_q;
		rear_nxt  = rear_q;
		count_nxt = count_q;
		done_nxt  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = front_q;
		unique case (mode_t'(mode))
			MODE_PUSH_FRONT: begin
				if (!full_now) begin
					mem_we    = cmd_take;
					mem_waddr = front_q;
					front_nxt = step_down(front_q, cap_q);
					count_nxt = count_q + CNT_W'(1);
					done_nxt  = 1'b1;
				end
			end
			MODE_PUSH_REAR: begin
				if (!full_now) begin
					mem_we    = cmd_take;
					mem_waddr = rear_q;
					rear_nxt  = step_up(rear_q, cap_q);
					count_nxt = count_q + CNT_W'(1);
					done_nxt  = 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (!empty_now) begin
					front_nxt = step_up(front_q, cap_q);
					count_nxt = count_q - CNT_W'(1);
					done_nxt  = 1'b1;
				end
			end
			MODE_POP_REAR: begin
				if (!empty_now) begin
					rear_nxt  = step_down(rear_q, cap_q);
					count_nxt = count_q - CNT_W'(1);
					done_nxt  = 1'b1;
				end
			end
			default: begin
				done_nxt = 1'b0;
			end
		endcase
	end

	// slots of the end items after this command
	assign rd_front_addr = step_up(front_nxt, cap_q);
	assign rd_rear_addr  = step_down(rear_nxt, cap_q);

	// memory: one write, two registered reads, write data forwarded on a hit
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= value;
		end
		if (cmd_take) begin
			rd_front_s1 <= (mem_we && (mem_waddr == rd_front_addr)) ? value
			                                                        : mem_q[rd_front_addr];
			rd_rear_s1  <= (mem_we && (mem_waddr == rd_rear_addr)) ? value
			                                                       : mem_q[rd_rear_addr];
		end
	end

	// control state; a capacity write empties the deque
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CNT_W'(DEPTH);
			front_q <= PTR_W'(DEPTH - 1);
			rear_q  <= '0;
			count_q <= '0;
		end else if (cfg_wr) begin
			cap_q   <= cfg_cap;
			front_q <= PTR_W'(cfg_cap - CNT_W'(1));
			rear_q  <= '0;
			count_q <= '0;
		end else if (cmd_take) begin
			front_q <= front_nxt;
			rear_q  <= rear_nxt;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			done_s1  <= done_nxt;
			empty_s1 <= (count_nxt == '0);
			full_s1  <= (count_nxt == cap_q);
		end
	end

	// result beat
	assign result_valid = valid_s1;
	assign accepted     = done_s1;
	assign is_empty     = empty_s1;
	assign is_full      = full_s1;
	assign front_item   = empty_s1 ? EMPTY_ITEM : rd_front_s1;
	assign rear_item    = empty_s1 ? EMPTY_ITEM : rd_rear_s1;

endmodule

// ----- hw/rtl/cdq_checker.sv -----
// ----------------------------------------------------------------------------
// cdq_checker
// port-level checks of the deque's command and result beats
// ----------------------------------------------------------------------------
module cdq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          result_valid,
	input logic                          accepted,
	input logic [cdq_pkg::ITEM_W-1:0]    front_item,
	input logic [cdq_pkg::ITEM_W-1:0]    rear_item,
	input logic                          is_empty,
	input logic                          is_full
);
	import cdq_pkg::*;

	// one result beat per command beat, in the following cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> result_valid)
		else $error("command beat without a result beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !result_valid)
		else $error("result beat without a command beat");

	// an empty deque shows the marker at both ends
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && is_empty) |->
			((front_item == EMPTY_ITEM) && (rear_item == EMPTY_ITEM)))
		else $error("empty deque shows an item");

	// capacity is at least one, so empty and full never coincide
	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(is_empty && is_full))
		else $error("deque reported empty and full");

	// a refused beat only happens on a full or an empty deque
	a_refused_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !accepted) |-> (is_empty || is_full))
		else $error("refused command on a deque neither full nor empty");

endmodule

bind circular_double_ended_queue cdq_checker u_cdq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.accepted     (accepted),
	.front_item   (front_item),
	.rear_item    (rear_item),
	.is_empty     (is_empty),
	.is_full      (is_full)
);

// ----- bench/circular_double_ended_queue_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_double_ended_queue_test
// self-checking bench for the ring-buffer deque: a cycle-level predictor runs
// beside the block, every command beat is mirrored into it and every result
// beat is compared field by field with the oldest predicted snapshot
// ----------------------------------------------------------------------------
module circular_double_ended_queue_test;

	import cdq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_LIMIT    = 50;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_ITEMS    = 115;
	localparam int PHASE_COUNT    = 10;
	localparam int FULL_RATE_ITEMS = 150;

	// byte addresses of the register window
	localparam logic [ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
	localparam logic [ADDR_W-1:0] UNUSED_ADDR   = {~REG_CAPACITY, 2'b00};

	// what the deque should look like after one command
	typedef struct packed {
		logic              accepted;
		logic [ITEM_W-1:0] front_item;
		logic [ITEM_W-1:0] rear_item;
		logic              is_empty;
		logic              is_full;
	} deque_snapshot_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [1:0] mode;
	logic signed [ITEM_W-1:0] value;
	logic result_valid;
	logic accepted;
	logic signed [ITEM_W-1:0] front_item;
	logic signed [ITEM_W-1:0] rear_item;
	logic is_empty;
	logic is_full;

	// predictor state: shadow ring, pointers, fill level and live capacity
	logic [ITEM_W-1:0] shadow_ring [DEPTH];
	int unsigned shadow_front;
	int unsigned shadow_rear;
	int unsigned shadow_count;
	int unsigned shadow_cap;

	deque_snapshot_t snapshots_due [$];

	int error_count = 0;
	int commands_taken = 0;
	int refused_seen = 0;
	int full_seen = 0;
	int capacity_writes = 0;
	bit idle_allowed = 1'b0;

	circular_double_ended_queue uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.value        (value),
		.result_valid (result_valid),
		.accepted     (accepted),
		.front_item   (front_item),
		.rear_item    (rear_item),
		.is_empty     (is_empty),
		.is_full      (is_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// ring steps wrap at the live capacity, not at the physical depth
	function automatic int unsigned ring_up(input int unsigned p);
		return (p + 1 >= shadow_cap) ? 0 : p + 1;
	endfunction

	function automatic int unsigned ring_down(input int unsigned p);
		return (p == 0) ? shadow_cap - 1 : p - 1;
	endfunction

	// front pointer sits on the slot the next front push writes
	function automatic void empty_shadow();
		shadow_front = shadow_cap - 1;
		shadow_rear  = 0;
		shadow_count = 0;
	endfunction

	// only the low five bits count; zero means one, oversize means full depth
	function automatic void load_capacity(input logic [DATA_W-1:0] raw);
		int unsigned c;
		c = 32'(raw[CAP_W-1:0]);
		if (c == 0)
			c = 1;
		if (c > DEPTH)
			c = DEPTH;
		shadow_cap = c;
		empty_shadow();
	endfunction

	function automatic deque_snapshot_t apply_command(input mode_t op,
			input logic [ITEM_W-1:0] item);
		deque_snapshot_t s;
		bit full_now;
		bit empty_now;
		full_now  = (shadow_count >= shadow_cap);
		empty_now = (shadow_count == 0);
		s = '0;
		case (op)
			MODE_PUSH_FRONT: if (!full_now) begin
				shadow_ring[shadow_front] = item;
				shadow_front = ring_down(shadow_front);
				shadow_count++;
				s.accepted = 1'b1;
			end
			MODE_PUSH_REAR: if (!full_now) begin
				shadow_ring[shadow_rear] = item;
				shadow_rear = ring_up(shadow_rear);
				shadow_count++;
				s.accepted = 1'b1;
			end
			MODE_POP_FRONT: if (!empty_now) begin
				shadow_front = ring_up(shadow_front);
				shadow_count--;
				s.accepted = 1'b1;
			end
			MODE_POP_REAR: if (!empty_now) begin
				shadow_rear = ring_down(shadow_rear);
				shadow_count--;
				s.accepted = 1'b1;
			end
		endcase
		// an empty deque shows the all-ones marker at both ends
		if (shadow_count == 0) begin
			s.front_item = EMPTY_ITEM;
			s.rear_item  = EMPTY_ITEM;
		end else begin
			s.front_item = shadow_ring[ring_up(shadow_front)];
			s.rear_item  = shadow_ring[ring_down(shadow_rear)];
		end
		s.is_empty = (shadow_count == 0);
		s.is_full  = (shadow_count == shadow_cap);
		return s;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// ------------------------------------------------------------------
	// monitor: mirrors command beats and config writes, checks result beats
	// all sampling happens at the rising edge, on pre-edge values
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_ring[i])
				shadow_ring[i] = '0;
			shadow_cap = DEPTH;
			empty_shadow();
			snapshots_due.delete();
		end else begin
			// result beat of the previous command comes out first
			if (result_valid) begin
				if (snapshots_due.size() == 0) begin
					report_mismatch("result beat with nothing predicted");
				end else begin
					deque_snapshot_t want;
					want = snapshots_due.pop_front();
					if (accepted !== want.accepted)
						report_mismatch($sformatf("accepted %b, predicted %b",
							accepted, want.accepted));
					if (front_item !== want.front_item)
						report_mismatch($sformatf("front_item %h, predicted %h",
							front_item, want.front_item));
					if (rear_item !== want.rear_item)
						report_mismatch($sformatf("rear_item %h, predicted %h",
							rear_item, want.rear_item));
					if (is_empty !== want.is_empty)
						report_mismatch($sformatf("is_empty %b, predicted %b",
							is_empty, want.is_empty));
					if (is_full !== want.is_full)
						report_mismatch($sformatf("is_full %b, predicted %b",
							is_full, want.is_full));
					if (!want.accepted)
						refused_seen++;
					if (want.is_full)
						full_seen++;
				end
			end
			// register write lands on the access edge; other indexes are ignored
			if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
				load_capacity(pwdata);
				capacity_writes++;
			end
			if (start && !busy) begin
				snapshots_due.push_back(apply_command(mode_t'(mode), value));
				commands_taken++;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too many cycles with no beat of any kind ends the run
	// ------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || result_valid || (psel && penable && pwrite))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// one command beat, with an optional idle burst in front of it
	task automatic send_command(input mode_t op, input logic [ITEM_W-1:0] item);
		int gap;
		gap = 0;
		if (idle_allowed && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 9);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode  <= op;
		value <= item;
		do
			@(posedge clk);
		while (!(start && !busy));
	endtask

	// sender holds off until every predicted result has come back
	task automatic wait_for_drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (snapshots_due.size() != 0);
		@(posedge clk);
	endtask

	// apb write: setup then access, only with the deque quiet
	task automatic write_register(input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		wait_for_drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// random item with the sign and all-ones corners well represented
	function automatic logic [ITEM_W-1:0] pick_item();
		case ($urandom_range(0, 7))
			0:       return {1'b1, {(ITEM_W-1){1'b0}}};
			1:       return {1'b0, {(ITEM_W-1){1'b1}}};
			2:       return '1;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic mode_t pick_mode(input bit push_side);
		if (push_side)
			return $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
		return $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
	endfunction

	// runs of pushes and runs of pops, long enough to hit full and empty,
	// with a sprinkle of fully random commands as noise
	task automatic run_bursts(input int quota);
		int sent;
		int run_len;
		bit push_side;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 9) == 0) begin
				send_command(mode_t'($urandom_range(0, 3)), pick_item());
				sent++;
			end else begin
				push_side = $urandom_range(0, 1);
				run_len = $urandom_range(1, DEPTH + 2);
				// a run never overshoots the quota
				if (run_len > quota - sent)
					run_len = quota - sent;
				repeat (run_len) begin
					send_command(pick_mode(push_side), pick_item());
					sent++;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// out of reset the deque is empty, so both pops are refused
	task automatic test_empty_pops();
		send_command(MODE_POP_FRONT, pick_item());
		send_command(MODE_POP_REAR, pick_item());
	endtask

	// signed corners through both ends, then unwind from both ends
	task automatic test_extreme_values();
		send_command(MODE_PUSH_REAR, 32'h7FFF_FFFF);
		send_command(MODE_PUSH_FRONT, 32'h8000_0000);
		send_command(MODE_PUSH_REAR, 32'hFFFF_FFFF);
		send_command(MODE_PUSH_FRONT, 32'h0000_0000);
		send_command(MODE_POP_FRONT, '0);
		send_command(MODE_POP_REAR, '1);
		send_command(MODE_POP_REAR, '0);
		send_command(MODE_POP_FRONT, '1);
	endtask

	// single-entry deque: full or empty after every accepted beat
	task automatic test_capacity_one();
		write_register(CAPACITY_ADDR, 32'd1);
		send_command(MODE_PUSH_REAR, 32'h1234_5678);
		send_command(MODE_PUSH_REAR, 32'hDEAD_BEEF);
		send_command(MODE_PUSH_FRONT, 32'hCAFE_F00D);
		send_command(MODE_POP_REAR, '0);
		send_command(MODE_POP_FRONT, '0);
		send_command(MODE_PUSH_FRONT, 32'hA5A5_5A5A);
		send_command(MODE_POP_FRONT, '0);
	endtask

	// clamping of zero and oversize values, upper data bits dropped,
	// a write empties the deque, a write to the unused index does nothing
	task automatic test_capacity_clamp();
		write_register(CAPACITY_ADDR, 32'd0);
		send_command(MODE_PUSH_REAR, 32'h0000_0011);
		send_command(MODE_PUSH_FRONT, 32'h0000_0022);
		write_register(CAPACITY_ADDR, 32'hFFFF_FFE3);
		send_command(MODE_POP_FRONT, '0);
		send_command(MODE_PUSH_REAR, 32'h0000_0033);
		send_command(MODE_PUSH_FRONT, 32'h0000_0044);
		send_command(MODE_PUSH_REAR, 32'h0000_0055);
		send_command(MODE_PUSH_FRONT, 32'h0000_0066);
		write_register(UNUSED_ADDR, 32'h0000_0001);
		send_command(MODE_POP_REAR, '0);
		write_register(CAPACITY_ADDR, 32'd17);
	endtask

	// phases at different capacities, idling switched per phase,
	// one sender hold-off somewhere in each phase
	task automatic test_random_traffic();
		logic [DATA_W-1:0] cap_word;
		int first_part;
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: cap_word = DEPTH;
				1: cap_word = 1;
				2: cap_word = 2;
				default:
					if ($urandom_range(0, 3) == 0)
						cap_word = $urandom;
					else
						cap_word = $urandom_range(1, DEPTH);
			endcase
			write_register(CAPACITY_ADDR, cap_word);
			idle_allowed = $urandom_range(0, 2) != 0;
			first_part = $urandom_range(10, PHASE_ITEMS - 10);
			run_bursts(first_part);
			wait_for_drain();
			run_bursts(PHASE_ITEMS - first_part);
		end
	endtask

	// closing stretch: a command in every cycle, no idling at all
	task automatic test_full_rate();
		write_register(CAPACITY_ADDR, 32'd8);
		idle_allowed = 1'b0;
		run_bursts(FULL_RATE_ITEMS);
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		start   = 1'b0;
		mode    = MODE_PUSH_FRONT;
		value   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_allowed = 1'b1;
		test_empty_pops();
		test_extreme_values();
		test_capacity_one();
		test_capacity_clamp();
		test_random_traffic();
		test_full_rate();

		// let the last result beats out, bounded, then let the bench settle
		start <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && snapshots_due.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (snapshots_due.size() != 0)
			report_mismatch($sformatf("%0d predicted results never came",
				snapshots_due.size()));

		$display("covered %0d commands, %0d refused, %0d ending full",
			commands_taken, refused_seen, full_seen);
		$display("over %0d capacity writes, %0d mismatches",
			capacity_writes, error_count);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
